FILE: src/ttd_pkg.sv
package ttd_pkg;

  // Command codes carried in the request word.
  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_REGISTER  = 2'd1,
    CMD_SET_DELAY = 2'd2,
    CMD_RESERVED  = 2'd3
  } cmd_code_t;

  // One request word.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  task_id;
    logic [15:0] period;
    logic [15:0] delay;
    logic        enabled;
  } request_t;

  // One result word.
  typedef struct packed {
    logic [15:0] fire_mask;
    logic [3:0]  assigned_id;
    logic        full_error;
    logic [3:0]  task_total;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic op;          // execute an immediate command and post its result
    logic scan_start;  // begin a tick scan at entry zero
    logic scan_step;   // write back the entry whose read data is present
    logic scan_end;    // this write-back is the last one; post the result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;  // no task registered
    logic wb_last;     // entry under write-back is the last registered one
  } dp_status_t;

endpackage

FILE: src/tick_task_dispatcher_core.sv
// Periodic task dispatcher. A word is taken when start is high and busy is low.
// Register, set-delay and unknown commands execute at once; their result appears
// on the cycle after acceptance. A tick walks the registered tasks one entry per
// cycle through the task table's single read port and keeps busy high until the
// last registered entry is written back; its result appears right after that
// write-back. A tick with no tasks behaves like the other commands. Each result
// is shown for exactly one cycle with done high, and the receiver has no way to
// hold it off; the next word may be accepted in the same cycle that a result is
// shown.
module tick_task_dispatcher_core
  import ttd_pkg::*;
#(
  parameter int MAX_TASKS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output result_t  result,
  output logic     done
);

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  ttd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (request.cmd),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  ttd_datapath #(
    .MAX_TASKS  (MAX_TASKS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctrl    (ctrl),
    .status  (status),
    .result  (result),
    .done    (done)
  );

endmodule

FILE: src/ttd_ram.sv
module ttd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ttd_ctrl.sv
module ttd_ctrl
  import ttd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd,
  input  dp_status_t status,
  output ctrl_cmd_t  ctrl,
  output logic       busy
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   go_scan;

  // Decode the accepted word and steer the datapath.
  always_comb begin
    accept          = (state == S_IDLE) && start;
    go_scan         = accept && (cmd == CMD_TICK) && !status.count_zero;
    ctrl.op         = accept && !go_scan;
    ctrl.scan_start = go_scan;
    ctrl.scan_step  = (state == S_SCAN);
    ctrl.scan_end   = (state == S_SCAN) && status.wb_last;
    busy            = (state == S_SCAN);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (go_scan) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.wb_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/ttd_datapath.sv
module ttd_datapath
  import ttd_pkg::*;
#(
  parameter int MAX_TASKS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  request_t   request,
  input  ctrl_cmd_t  ctrl,
  output dp_status_t status,
  output result_t    result,
  output logic       done
);

  localparam int IDX_W  = $clog2(MAX_TASKS);
  localparam int CB     = COUNT_BITS;
  localparam int TASK_W = 2 * CB + 1;

  // Task table word: {enable, period, period counter}.
  logic [IDX_W-1:0]  task_count;
  logic [IDX_W-1:0]  task_count_next;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  wb_idx;
  logic [15:0]       fire_acc;
  logic [15:0]       fire_next;

  logic              task_we;
  logic [IDX_W-1:0]  task_waddr;
  logic [TASK_W-1:0] task_wdata;
  logic [TASK_W-1:0] task_rdata;
  logic              delay_we;
  logic [IDX_W-1:0]  delay_waddr;
  logic [CB-1:0]     delay_wdata;
  logic [CB-1:0]     delay_rdata;

  logic [CB-1:0]     per_in;
  logic [CB-1:0]     dly_in;
  logic              reg_ok;
  logic              set_ok;

  logic              ent_en;
  logic [CB-1:0]     ent_per;
  logic [CB-1:0]     ent_cnt;
  logic [CB-1:0]     dly_dec;
  logic [CB-1:0]     cnt_inc;
  logic [CB-1:0]     cnt_new;
  logic              fired;

  ttd_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_task_ram (
    .clk   (clk),
    .we    (task_we),
    .waddr (task_waddr),
    .wdata (task_wdata),
    .raddr (rd_idx),
    .rdata (task_rdata)
  );

  ttd_ram #(.WIDTH(CB), .DEPTH(MAX_TASKS)) u_delay_ram (
    .clk   (clk),
    .we    (delay_we),
    .waddr (delay_waddr),
    .wdata (delay_wdata),
    .raddr (rd_idx),
    .rdata (delay_rdata)
  );

  // Immediate command decode.
  always_comb begin
    per_in = CB'(request.period);
    dly_in = CB'(request.delay);
    reg_ok = (request.cmd == CMD_REGISTER) &&
             (32'(task_count) < 32'(MAX_TASKS - 1));
    set_ok = (request.cmd == CMD_SET_DELAY) &&
             (32'(request.task_id) < 32'(MAX_TASKS));
    task_count_next = (ctrl.op && reg_ok) ? task_count + IDX_W'(1) : task_count;
  end

  // Tick update of the entry whose read data is present.
  always_comb begin
    ent_en  = task_rdata[TASK_W-1];
    ent_per = task_rdata[2*CB-1:CB];
    ent_cnt = task_rdata[CB-1:0];
    dly_dec = delay_rdata;
    cnt_new = ent_cnt;
    cnt_inc = ent_cnt + CB'(1);
    fired   = 1'b0;
    if (ent_en) begin
      if (delay_rdata != '0) begin
        dly_dec = delay_rdata - CB'(1);
      end
      if (dly_dec == '0) begin
        if (ent_per == '0) begin
          cnt_new = '0;
        end else if (cnt_inc >= ent_per) begin
          cnt_new = '0;
          fired   = 1'b1;
        end else begin
          cnt_new = cnt_inc;
        end
      end
    end
    // Shifting past bit 15 drops the bit for tasks beyond sixteen.
    fire_next = fire_acc | ({15'd0, fired} << wb_idx);
  end

  // Write port steering: scan write-back or an immediate command.
  always_comb begin
    task_we     = 1'b0;
    task_waddr  = task_count;
    task_wdata  = {request.enabled, per_in, {CB{1'b0}}};
    delay_we    = 1'b0;
    delay_waddr = task_count;
    delay_wdata = dly_in;
    if (ctrl.scan_step) begin
      task_we     = 1'b1;
      task_waddr  = wb_idx;
      task_wdata  = {ent_en, ent_per, cnt_new};
      delay_we    = 1'b1;
      delay_waddr = wb_idx;
      delay_wdata = dly_dec;
    end else if (ctrl.op && reg_ok) begin
      task_we  = 1'b1;
      delay_we = 1'b1;
    end else if (ctrl.op && set_ok) begin
      delay_we    = 1'b1;
      delay_waddr = IDX_W'(request.task_id);
    end
  end

  always_comb begin
    status.count_zero = (task_count == '0);
    status.wb_last    = (wb_idx == task_count - IDX_W'(1));
  end

  // Control registers: task count, scan index and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
      rd_idx     <= '0;
      done       <= 1'b0;
    end else begin
      task_count <= task_count_next;
      done       <= ctrl.op || ctrl.scan_end;
      if (ctrl.scan_start) begin
        rd_idx <= IDX_W'(1);
      end else if (ctrl.scan_end) begin
        rd_idx <= '0;
      end else if (ctrl.scan_step) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
    end
  end

  // Payload registers: write-back index, fire accumulator and result word.
  always_ff @(posedge clk) begin
    wb_idx <= rd_idx;
    if (ctrl.scan_start) begin
      fire_acc <= '0;
    end else if (ctrl.scan_step) begin
      fire_acc <= fire_next;
    end
    if (ctrl.op) begin
      result.fire_mask   <= '0;
      result.assigned_id <= reg_ok ? 4'(task_count) : 4'd0;
      result.full_error  <= (request.cmd == CMD_REGISTER) && !reg_ok;
      result.task_total  <= 4'(task_count_next);
    end else if (ctrl.scan_end) begin
      result.fire_mask   <= fire_next;
      result.assigned_id <= 4'd0;
      result.full_error  <= 1'b0;
      result.task_total  <= 4'(task_count);
    end
  end

endmodule

FILE: tb/tb_tick_task_dispatcher_core.sv
`timescale 1ns / 100ps

module tb_tick_task_dispatcher_core;
  import ttd_pkg::*;

  // Tracks the task table and checks every result word against its prediction.
  class task_table_scoreboard;
    logic [4:0]  task_count;
    logic [15:0] delay_left [16];
    logic [15:0] period_len [16];
    logic [15:0] period_cnt [16];
    logic        task_on    [16];
    result_t     pending_results [$];
    int          mismatches;

    function new();
      task_count = '0;
      mismatches = 0;
      foreach (delay_left[i]) begin
        delay_left[i] = '0;
        period_len[i] = '0;
        period_cnt[i] = '0;
        task_on[i]    = 1'b0;
      end
    endfunction

    // Advance every registered, enabled task by one tick and collect the fire mask.
    function logic [15:0] scan_tick();
      logic [15:0] mask;
      mask = '0;
      for (int i = 0; i < task_count; i++) begin
        if (!task_on[i]) continue;
        // The delay counts down and sticks at zero; the period runs only at zero.
        if (delay_left[i] != 0) delay_left[i] = delay_left[i] - 16'd1;
        if (delay_left[i] != 0) continue;
        if (period_len[i] == 0) begin
          period_cnt[i] = '0;
          continue;
        end
        period_cnt[i] = period_cnt[i] + 16'd1;
        if (period_cnt[i] >= period_len[i]) begin
          period_cnt[i] = '0;
          mask[i] = 1'b1;
        end
      end
      return mask;
    endfunction

    // Apply one accepted word to the table and queue the result it should produce.
    function void note_word(request_t w);
      result_t want;
      want = '0;
      case (cmd_code_t'(w.cmd))
        CMD_TICK: begin
          want.fire_mask = scan_tick();
        end
        CMD_REGISTER: begin
          if (task_count < 5'd15) begin
            period_len[task_count] = w.period;
            delay_left[task_count] = w.delay;
            period_cnt[task_count] = '0;
            task_on[task_count]    = w.enabled;
            want.assigned_id       = task_count[3:0];
            task_count             = task_count + 5'd1;
          end else begin
            want.full_error = 1'b1;
          end
        end
        CMD_SET_DELAY: begin
          delay_left[w.task_id] = w.delay;
        end
        default: begin
        end
      endcase
      want.task_total = task_count[3:0];
      pending_results.push_back(want);
    endfunction

    function void report_field(string field, logic [15:0] want_v, logic [15:0] got_v);
      if (want_v !== got_v) begin
        mismatches++;
        $display("%0t: %s expected %h got %h", $time, field, want_v, got_v);
      end
    endfunction

    // Compare a result word with the oldest prediction, field by field.
    function void check_word(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none got %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      report_field("fire_mask", want.fire_mask, got.fire_mask);
      report_field("assigned_id", 16'(want.assigned_id), 16'(got.assigned_id));
      report_field("full_error", 16'(want.full_error), 16'(got.full_error));
      report_field("task_total", 16'(want.task_total), 16'(got.task_total));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  request_t request = '0;
  result_t  result;
  logic     done;

  task_table_scoreboard sb;
  int idle_pct_by_phase [4] = '{0, 88, 0, 27};

  tick_task_dispatcher_core DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .result  (result),
    .done    (done)
  );

  always #2 clk = ~clk;

  // Results are sampled mid-cycle, away from the edge where they change.
  always @(negedge clk) begin
    if (!rst && done) sb.check_word(result);
  end

  function automatic request_t make_word(cmd_code_t op, logic [3:0] id, logic [15:0] per,
                                         logic [15:0] dly, logic en);
    request_t w;
    w.cmd     = op;
    w.task_id = id;
    w.period  = per;
    w.delay   = dly;
    w.enabled = en;
    return w;
  endfunction

  // Mostly ticks and short delays so that tasks keep firing; fields not used by
  // a command still carry random bits.
  function automatic request_t random_word();
    request_t w;
    int pick;
    w.task_id = 4'($urandom);
    w.period  = 16'($urandom);
    w.delay   = 16'($urandom);
    w.enabled = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      w.cmd = CMD_TICK;
    end else if (pick < 59) begin
      w.cmd = CMD_REGISTER;
      if ($urandom_range(0, 9) < 8) w.period = 16'($urandom_range(0, 6));
      if ($urandom_range(0, 9) < 8) w.delay = 16'($urandom_range(0, 3));
      w.enabled = ($urandom_range(0, 4) != 0);
    end else if (pick < 92) begin
      w.cmd = CMD_SET_DELAY;
      if ($urandom_range(0, 9) < 9) w.delay = 16'($urandom_range(0, 4));
    end else begin
      w.cmd = CMD_RESERVED;
    end
    return w;
  endfunction

  // Offer one word, optionally after an idle gap, and note it once it is taken.
  task automatic send_word(input request_t w, input int idle_pct);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request <= w;
    start   <= 1'b1;
    @(negedge clk);
    while (busy) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    sb.note_word(w);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed words: empty table, unused command, field extremes, disabled task.
    send_word(make_word(CMD_TICK, 4'h0, 16'h0000, 16'h0000, 1'b0), 0);
    send_word(make_word(CMD_RESERVED, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1), 0);
    send_word(make_word(CMD_SET_DELAY, 4'hF, 16'h0000, 16'hFFFF, 1'b0), 0);
    send_word(make_word(CMD_REGISTER, 4'h0, 16'h0000, 16'h0000, 1'b1), 0);
    send_word(make_word(CMD_REGISTER, 4'h0, 16'h0001, 16'h0000, 1'b1), 0);
    send_word(make_word(CMD_REGISTER, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1), 0);
    send_word(make_word(CMD_REGISTER, 4'h5, 16'h0002, 16'h0001, 1'b0), 0);
    send_word(make_word(CMD_REGISTER, 4'hA, 16'h0003, 16'h0002, 1'b1), 0);
    repeat (3) send_word(make_word(CMD_TICK, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1), 0);
    send_word(make_word(CMD_SET_DELAY, 4'h1, 16'h0000, 16'h0002, 1'b0), 0);
    repeat (2) send_word(make_word(CMD_TICK, 4'h0, 16'h0000, 16'h0000, 1'b0), 0);
    // The long-period task starts counting once its delay is cleared.
    send_word(make_word(CMD_SET_DELAY, 4'h2, 16'h0000, 16'h0000, 1'b0), 0);
    send_word(make_word(CMD_SET_DELAY, 4'h3, 16'h0000, 16'h0000, 1'b1), 0);
    repeat (3) send_word(make_word(CMD_TICK, 4'h0, 16'h0000, 16'h0000, 1'b0), 0);

    // Random words, cycling through the idle settings every hundred words.
    for (int n = 0; n < 1100; n++) begin
      send_word(random_word(), idle_pct_by_phase[(n / 100) % 4]);
    end
    start <= 1'b0;

    // Drain the outstanding results, then allow for a late stray word.
    while (sb.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_tick_task_dispatcher_core: PASS");
    end else begin
      $display("tb_tick_task_dispatcher_core: FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb_tick_task_dispatcher_core: FAIL");
    $finish;
  end

endmodule
